### rtl/core/mcpg_pkg.sv
// mcpg_pkg: shared widths, codes and types of the midpoint circle point generator
// used by the front, queue, back and top level files; depends on nothing
`default_nettype none

package mcpg_pkg;

    localparam int MAX_RADIUS  = 1023;
    localparam int QUEUE_DEPTH = 2;

    localparam int RAD_W   = 10;
    localparam int COORD_W = 11;
    localparam int POSZ_W  = 12;
    localparam int DEC_W   = 14;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    // one iteration as handed from front to back: pre-update position
    typedef struct packed {
        logic [COORD_W-1:0]       x;
        logic signed [POSZ_W-1:0] z;
        logic                     done;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

### rtl/core/mcpg_front.sv
// mcpg_front: accepts start and advance items, runs the midpoint decision step
// and pushes one iteration entry per effective item; depends on mcpg_pkg
`default_nettype none

module mcpg_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_action,
    input  logic [mcpg_pkg::RAD_W-1:0]     i_radius,
    input  mcpg_pkg::t_qstat               i_qstat,
    output logic                           o_push,
    output mcpg_pkg::t_entry               o_entry
);
    import mcpg_pkg::*;

    logic [COORD_W-1:0]       r_pos_x, n_pos_x;
    logic signed [POSZ_W-1:0] r_pos_z, n_pos_z;
    logic signed [DEC_W-1:0]  r_dec, n_dec;
    logic                     r_active, n_active;

    logic                     accept;
    logic                     start;
    logic [RAD_W-1:0]         rad_sat;
    logic [COORD_W-1:0]       x0, x1;
    logic signed [POSZ_W-1:0] z0, z1, x1s;
    logic signed [DEC_W-1:0]  d0, d1, xd, zd;
    logic                     done;

    assign o_in_ready = !i_qstat.full;
    assign accept     = i_in_valid && o_in_ready;
    assign start      = (i_action == ACT_START);
    assign o_push     = accept && (start || r_active);

    always_comb begin
        rad_sat = (16'(i_radius) > 16'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : i_radius;
        if (start) begin
            x0 = '0;
            z0 = POSZ_W'(rad_sat);
            d0 = DEC_W'(3) - (DEC_W'(rad_sat) << 1);
        end else begin
            x0 = r_pos_x;
            z0 = r_pos_z;
            d0 = r_dec;
        end
        xd = DEC_W'(x0);
        zd = DEC_W'(z0);
        x1 = x0 + COORD_W'(1);
        if (d0[DEC_W-1]) begin
            d1 = d0 + (xd <<< 2) + DEC_W'(6);
            z1 = z0;
        end else begin
            d1 = d0 + ((xd - zd) <<< 2) + DEC_W'(10);
            z1 = z0 - POSZ_W'(1);
        end
        x1s  = POSZ_W'(x1);
        done = (x1s > z1);

        n_pos_x  = r_pos_x;
        n_pos_z  = r_pos_z;
        n_dec    = r_dec;
        n_active = r_active;
        if (o_push) begin
            n_pos_x  = x1;
            n_pos_z  = z1;
            n_dec    = d1;
            n_active = !done;
        end
    end

    assign o_entry.x    = x0;
    assign o_entry.z    = z0;
    assign o_entry.done = done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x  <= '0;
            r_pos_z  <= '0;
            r_dec    <= '0;
            r_active <= 1'b0;
        end else begin
            r_pos_x  <= n_pos_x;
            r_pos_z  <= n_pos_z;
            r_dec    <= n_dec;
            r_active <= n_active;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mcpg_queue.sv
// mcpg_queue: small register queue of iteration entries between front and back
// head is readable without popping; depends on mcpg_pkg
`default_nettype none

module mcpg_queue #(
    parameter int DEPTH = mcpg_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mcpg_pkg::t_entry i_entry,
    input  logic             i_pop,
    output mcpg_pkg::t_entry o_head,
    output mcpg_pkg::t_qstat o_qstat
);
    import mcpg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push, do_pop;

    assign o_qstat.full  = (r_count == CNT_W'(DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mcpg_back.sv
// mcpg_back: expands the queue head into eight symmetric points in the output register,
// one per cycle unless the output stalls; depends on mcpg_pkg
`default_nettype none

module mcpg_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mcpg_pkg::t_entry                   i_head,
    input  mcpg_pkg::t_qstat                   i_qstat,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [mcpg_pkg::COORD_W-1:0] o_point_x,
    output logic signed [mcpg_pkg::COORD_W-1:0] o_point_z,
    output logic                               o_last_of_step,
    output logic                               o_circle_done
);
    import mcpg_pkg::*;

    logic [2:0]                r_cnt, n_cnt;
    logic                      r_valid, n_valid;
    logic signed [COORD_W-1:0] r_px, n_px;
    logic signed [COORD_W-1:0] r_pz, n_pz;
    logic                      r_last, n_last;
    logic                      r_done, n_done;

    logic                      load;
    logic signed [COORD_W-1:0] sx, sz;

    assign load  = !r_valid || i_out_ready;
    assign o_pop = load && !i_qstat.empty && (r_cnt == 3'd7);
    assign sx    = i_head.x;
    assign sz    = i_head.z[COORD_W-1:0];

    always_comb begin
        n_cnt   = r_cnt;
        n_valid = r_valid;
        n_px    = r_px;
        n_pz    = r_pz;
        n_last  = r_last;
        n_done  = r_done;
        if (load) begin
            n_valid = !i_qstat.empty;
            if (!i_qstat.empty) begin
                n_cnt  = r_cnt + 3'd1;
                n_last = (r_cnt == 3'd7);
                n_done = i_head.done;
                // octant order: four with x first, then four with z first
                unique case (r_cnt)
                    3'd0: begin n_px = sx;  n_pz = sz;  end
                    3'd1: begin n_px = sx;  n_pz = -sz; end
                    3'd2: begin n_px = -sx; n_pz = -sz; end
                    3'd3: begin n_px = -sx; n_pz = sz;  end
                    3'd4: begin n_px = sz;  n_pz = sx;  end
                    3'd5: begin n_px = sz;  n_pz = -sx; end
                    3'd6: begin n_px = -sz; n_pz = -sx; end
                    3'd7: begin n_px = -sz; n_pz = sx;  end
                endcase
            end
        end
    end

    assign o_out_valid    = r_valid;
    assign o_point_x      = r_px;
    assign o_point_z      = r_pz;
    assign o_last_of_step = r_last;
    assign o_circle_done  = r_done;

    always_ff @(posedge i_clk) begin
        r_px   <= n_px;
        r_pz   <= n_pz;
        r_last <= n_last;
        r_done <= n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

### rtl/core/midpoint_circle_point_generator.sv
// midpoint_circle_point_generator: top level, front step unit, entry queue, point expander
// depends on mcpg_pkg, mcpg_front, mcpg_queue, mcpg_back
//
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    i_action, i_radius
// out      output     o_out_valid / i_out_ready  o_point_x, o_point_z, o_last_of_step,
//                                                o_circle_done
//
// a start or active advance item is pushed into the queue as it is accepted and yields
// eight points, one per cycle from the back while the output is not stalled; a steady
// stream is limited by the single output channel. the first point passes the queue entry
// and the output register. an advance item while idle is taken and yields nothing.
// the queue lets the front take items while the back is stalled, until it is full.
// synchronous active-low reset empties the queue and clears the circle state.
`default_nettype none

module midpoint_circle_point_generator #(
    parameter int QUEUE_DEPTH = mcpg_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic [mcpg_pkg::RAD_W-1:0]          i_radius,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [mcpg_pkg::COORD_W-1:0] o_point_x,
    output logic signed [mcpg_pkg::COORD_W-1:0] o_point_z,
    output logic                                o_last_of_step,
    output logic                                o_circle_done
);
    import mcpg_pkg::*;

    t_entry entry, head;
    t_qstat qstat;
    logic   push, pop;

    mcpg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_radius   (i_radius),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_entry    (entry)
    );

    mcpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    mcpg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_qstat        (qstat),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_point_x      (o_point_x),
        .o_point_z      (o_point_z),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

`ifndef NO_ASSERTIONS
    // within an iteration the next point follows at once with the same done flag
    a_points_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_of_step) |=>
            (o_out_valid && $stable(o_circle_done)))
        else $error("iteration points not contiguous");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && qstat.full))
        else $error("entry pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && qstat.empty))
        else $error("entry popped from empty queue");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire
